[sv/rty_pkg.sv]
// Shared types and constants for the RGB to Y/Pb/Pr converter.
package rty_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 16;
  localparam int SCALE_BITS    = 16;
  localparam int OUT_BITS      = FRACTION_BITS + 1;
  localparam int COEF_BITS     = 21;
  localparam int DEN_BITS      = 36;
  localparam int NUM_BITS      = 38;
  localparam int Q_BITS        = OUT_BITS;
  localparam int N_BITS        = DEN_BITS + FRACTION_BITS + 2;
  localparam int D_BITS        = DEN_BITS + 1;
  localparam int MAT_STAGES    = 5;
  localparam int PIPE_STAGES   = MAT_STAGES + Q_BITS;

  localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(255);
  localparam logic [SCALE_BITS-1:0] SAMPLE_MASK =
    SCALE_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [DEN_BITS-1:0] COEF_ONE = DEN_BITS'(1000000);

  localparam logic signed [COEF_BITS-1:0] MAT [3][3] = '{
    '{ 21'sd299000,  21'sd587000,  21'sd114000},
    '{-21'sd168736, -21'sd331264,  21'sd500000},
    '{ 21'sd500000, -21'sd418688, -21'sd81312}
  };

  typedef logic [SCALE_BITS-1:0] sample_t;

  typedef struct packed {
    logic       over;
    logic       zero;
    logic [2:0] neg;
  } side_t;

endpackage

[sv/rty_matrix.sv]
// Clamp, BT.601 matrix, range clamp and divider operand setup (five stages).
module rty_matrix (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  rty_pkg::sample_t             scale_i,
  input  rty_pkg::sample_t             red_i,
  input  rty_pkg::sample_t             green_i,
  input  rty_pkg::sample_t             blue_i,
  output logic [rty_pkg::N_BITS-1:0]   n_o [3],
  output logic [rty_pkg::D_BITS-1:0]   d_o,
  output rty_pkg::side_t               side_o
);
  import rty_pkg::*;

  sample_t                      samp_in [3];
  sample_t                      s1_d [3];
  sample_t                      s1_q [3];
  logic                         over1_d;
  logic [DEN_BITS-1:0]          den1_q, den2_q, den3_q, den4_q;
  logic                         over1_q, over2_q, over3_q, over4_q, over5_q;
  logic                         zero1_q, zero2_q, zero3_q, zero4_q, zero5_q;
  logic signed [NUM_BITS-1:0]   p2_q [3][3];
  logic signed [NUM_BITS-1:0]   num3_q [3];
  logic [DEN_BITS-1:0]          mag4_d [3];
  logic [DEN_BITS-1:0]          mag4_q [3];
  logic [2:0]                   neg4_d, neg4_q, neg5_q;
  logic [N_BITS-1:0]            n5_q [3];
  logic [D_BITS-1:0]            d5_q;

  always_comb begin
    samp_in[0] = red_i & SAMPLE_MASK;
    samp_in[1] = green_i & SAMPLE_MASK;
    samp_in[2] = blue_i & SAMPLE_MASK;
    over1_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (samp_in[i] > scale_i) begin
        s1_d[i] = scale_i;
        over1_d = 1'b1;
      end else begin
        s1_d[i] = samp_in[i];
      end
    end
  end

  always_comb begin
    logic [DEN_BITS-1:0]        hi;
    logic signed [NUM_BITS-1:0] hi_s, lo_s, c;
    for (int k = 0; k < 3; k++) begin
      hi   = (k == 0) ? den3_q : (den3_q >> 1);
      hi_s = $signed({2'b00, hi});
      lo_s = (k == 0) ? '0 : -hi_s;
      if (num3_q[k] > hi_s) c = hi_s;
      else if (num3_q[k] < lo_s) c = lo_s;
      else c = num3_q[k];
      neg4_d[k] = c[NUM_BITS-1];
      mag4_d[k] = neg4_d[k] ? DEN_BITS'(-c) : DEN_BITS'(c);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q    <= s1_d;
      over1_q <= over1_d;
      zero1_q <= (scale_i == '0);
      den1_q  <= COEF_ONE * DEN_BITS'(scale_i);

      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          p2_q[k][i] <= NUM_BITS'(MAT[k][i]) * NUM_BITS'($signed({1'b0, s1_q[i]}));
        end
      end
      den2_q  <= den1_q;
      over2_q <= over1_q;
      zero2_q <= zero1_q;

      for (int k = 0; k < 3; k++) begin
        num3_q[k] <= p2_q[k][0] + p2_q[k][1] + p2_q[k][2];
      end
      den3_q  <= den2_q;
      over3_q <= over2_q;
      zero3_q <= zero2_q;

      mag4_q  <= mag4_d;
      neg4_q  <= neg4_d;
      den4_q  <= den3_q;
      over4_q <= over3_q;
      zero4_q <= zero3_q;

      for (int k = 0; k < 3; k++) begin
        n5_q[k] <= (N_BITS'(mag4_q[k]) << (FRACTION_BITS + 1)) + N_BITS'(den4_q);
      end
      d5_q    <= D_BITS'(den4_q) << 1;
      neg5_q  <= neg4_q;
      over5_q <= over4_q;
      zero5_q <= zero4_q;
    end
  end

  assign n_o         = n5_q;
  assign d_o         = d5_q;
  assign side_o.over = over5_q;
  assign side_o.zero = zero5_q;
  assign side_o.neg  = neg5_q;

endmodule

[sv/rty_divider.sv]
// Pipelined restoring divider, one quotient bit per stage.
module rty_divider (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [rty_pkg::N_BITS-1:0] n_i,
  input  logic [rty_pkg::D_BITS-1:0] d_i,
  output logic [rty_pkg::Q_BITS-1:0] q_o
);
  import rty_pkg::*;

  logic [N_BITS-1:0] r_q [Q_BITS];
  logic [D_BITS-1:0] d_q [Q_BITS];
  logic [Q_BITS-1:0] q_q [Q_BITS];

  for (genvar g = 0; g < Q_BITS; g++) begin : g_stage
    localparam int B = Q_BITS - 1 - g;
    logic [N_BITS-1:0] src_r;
    logic [D_BITS-1:0] src_d;
    logic [Q_BITS-1:0] src_q;
    logic [N_BITS:0]   trial;

    if (g == 0) begin : g_first
      assign src_r = n_i;
      assign src_d = d_i;
      assign src_q = '0;
    end else begin : g_next
      assign src_r = r_q[g-1];
      assign src_d = d_q[g-1];
      assign src_q = q_q[g-1];
    end

    assign trial = {1'b0, src_r} - ((N_BITS + 1)'(src_d) << B);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[g] <= src_d;
        if (!trial[N_BITS]) begin
          r_q[g] <= trial[N_BITS-1:0];
          q_q[g] <= src_q | (Q_BITS'(1) << B);
        end else begin
          r_q[g] <= src_r;
          q_q[g] <= src_q;
        end
      end
    end
  end

  assign q_o = q_q[Q_BITS-1];

endmodule

[sv/rgb_to_ypbpr_converter.sv]
// Top level: BT.601 RGB to Y/Pb/Pr converter with scale register.
// Pipeline: 5 matrix stages, 17 divider stages and one output register.
// Throughput: one pixel per cycle while the output is not stalled; each
// divider stage resolves one quotient bit. The whole pipe halts while
// the output register holds an untaken result. Reset clears valid bits and
// sets sample_scale to 255.
module rgb_to_ypbpr_converter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [rty_pkg::SCALE_BITS-1:0]        sample_scale_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [rty_pkg::SCALE_BITS-1:0]        red_sample_i,
  input  logic [rty_pkg::SCALE_BITS-1:0]        green_sample_i,
  input  logic [rty_pkg::SCALE_BITS-1:0]        blue_sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [rty_pkg::OUT_BITS-1:0]          luma_o,
  output logic signed [rty_pkg::OUT_BITS-1:0]   chroma_blue_o,
  output logic signed [rty_pkg::OUT_BITS-1:0]   chroma_red_o,
  output logic                                  sample_over_scale_o
);
  import rty_pkg::*;

  logic                    en;
  sample_t                 scale_q;
  logic [PIPE_STAGES-1:0]  valid_q;
  logic [N_BITS-1:0]       n_w [3];
  logic [D_BITS-1:0]       d_w;
  side_t                   side_w;
  side_t                   side_q [Q_BITS];
  logic [Q_BITS-1:0]       q_w [3];
  logic [OUT_BITS-1:0]     res_d [3];
  logic [OUT_BITS-1:0]     res_q [3];
  logic                    out_valid_q;
  logic                    over_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_valid_i) begin
      scale_q <= sample_scale_i;
    end
  end

  rty_matrix u_matrix (
    .clk_i   (clk_i),
    .en_i    (en),
    .scale_i (scale_q),
    .red_i   (red_sample_i),
    .green_i (green_sample_i),
    .blue_i  (blue_sample_i),
    .n_o     (n_w),
    .d_o     (d_w),
    .side_o  (side_w)
  );

  for (genvar k = 0; k < 3; k++) begin : g_lane
    rty_divider u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .n_i   (n_w[k]),
      .d_i   (d_w),
      .q_o   (q_w[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_w;
      for (int s = 1; s < Q_BITS; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (side_q[Q_BITS-1].zero) res_d[k] = '0;
      else if (side_q[Q_BITS-1].neg[k]) res_d[k] = OUT_BITS'(-q_w[k]);
      else res_d[k] = OUT_BITS'(q_w[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_q     <= {valid_q[PIPE_STAGES-2:0], in_valid_i};
      out_valid_q <= valid_q[PIPE_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res_d;
      over_q <= side_q[Q_BITS-1].over;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign luma_o              = res_q[0];
  assign chroma_blue_o       = $signed(res_q[1]);
  assign chroma_red_o        = $signed(res_q[2]);
  assign sample_over_scale_o = over_q;

`ifndef ASSERT_OFF
  a_luma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> luma_o <= OUT_BITS'(65536))
    else $error("luma out of range");

  a_chroma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (chroma_blue_o <= 17'sd32768 && chroma_blue_o >= -17'sd32768 &&
                     chroma_red_o <= 17'sd32768 && chroma_red_o >= -17'sd32768))
    else $error("chroma out of range");

  a_zero_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && scale_q == '0) |-> (luma_o == '0 && chroma_blue_o == '0 &&
                                        chroma_red_o == '0))
    else $error("nonzero result with zero scale");
`endif

endmodule
